FILE: design/assert_macros.svh
// Assertion macros for the RTL files; the job queue includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/fsdi_pkg.sv
// Types, constants and helper functions of the Stokes detector integrator.
`timescale 1ns / 1ps
`default_nettype none
package fsdi_pkg;

  localparam int MAX_WINDOW    = 64;
  localparam int SAMPLE_BITS   = 8;
  localparam int FRACTION_BITS = 8;
  localparam int SLOT_BITS     = 6;
  localparam int WIDTH_BITS    = 7;
  localparam int COUNT_BITS    = 17;
  localparam int COUNT_LIMIT   = 65536;
  localparam int DET_BITS      = 18;
  localparam int RUN_BITS      = 24;
  localparam int INT_BITS      = 41;
  localparam int DIV_BITS      = 23;
  localparam int MAG_BITS      = INT_BITS + FRACTION_BITS;
  localparam int STEP_BITS     = 6;
  localparam int QDEPTH        = 4;
  localparam int QPTR_BITS     = 2;
  localparam int QCNT_BITS     = 3;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 17;
  localparam int OUT_IQ_BITS   = 25;
  localparam int OUT_UV_BITS   = 26;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_BOXCAR_WIDTH      = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_INTEGRATION_COUNT = 2'd1;

  typedef logic signed [DET_BITS-1:0] det_t;

  typedef struct packed {
    det_t i;
    det_t q;
    det_t u;
    det_t v;
  } det4_t;

  // One finished integration waiting for division
  typedef struct packed {
    logic signed [INT_BITS-1:0] i;
    logic signed [INT_BITS-1:0] q;
    logic signed [INT_BITS-1:0] u;
    logic signed [INT_BITS-1:0] v;
  } job_t;

  // Queue status seen by the front end
  typedef struct packed {
    logic [QCNT_BITS-1:0] count;
    logic                 empty;
  } qstat_t;

  typedef struct packed {
    logic [DIV_BITS-1:0] rem;
    logic [MAG_BITS-1:0] num;
  } lane_t;

  // One restoring division step: quotient bit shifts into num
  function automatic lane_t div_step(lane_t cur, logic [DIV_BITS-1:0] div);
    logic [DIV_BITS:0] rem_sh;
    logic [DIV_BITS:0] diff;
    logic              ge;
    lane_t             nxt;
    rem_sh = {cur.rem, cur.num[MAG_BITS-1]};
    diff   = rem_sh - {1'b0, div};
    ge     = (rem_sh >= {1'b0, div});
    nxt.rem = ge ? diff[DIV_BITS-1:0] : rem_sh[DIV_BITS-1:0];
    nxt.num = {cur.num[MAG_BITS-2:0], ge};
    return nxt;
  endfunction

  // Magnitude of a total, scaled by the fraction bits
  function automatic logic [MAG_BITS-1:0] scaled_mag(logic signed [INT_BITS-1:0] v);
    logic [INT_BITS-1:0] mag;
    mag = v[INT_BITS-1] ? (~v + 1'b1) : v;
    return {mag, {FRACTION_BITS{1'b0}}};
  endfunction

endpackage
`default_nettype wire

FILE: design/fsdi_queue.sv
// Short job queue between the detector front end and the divider back end.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module fsdi_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire fsdi_pkg::job_t job_in,
  input  wire logic          pop,
  output fsdi_pkg::job_t     job_out,
  output fsdi_pkg::qstat_t   stat
);
  import fsdi_pkg::*;

  job_t                 entries [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= job_in;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (!push && pop) count <= count - 1'b1;
    end
  end

  assign job_out    = entries[rd_ptr];
  assign stat.count = count;
  assign stat.empty = (count == '0);

  `ASSERT_IMPLY(a_no_overflow, clk, rst, push && !pop, count < QCNT_BITS'(QDEPTH), "job queue overflow")
  `ASSERT_IMPLY(a_no_underflow, clk, rst, pop, count != '0, "job queue underflow")
  `ASSERT_NEXT(a_count_hold, clk, rst, !push && !pop, $stable(count), "job count moved while idle")

endmodule
`default_nettype wire

FILE: design/fsdi_front.sv
// Front end: configuration, detection, boxcar window and integrator.
`timescale 1ns / 1ps
`default_nettype none
module fsdi_front (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_write,
  input  wire logic [fsdi_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  wire logic [fsdi_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  wire logic                                  push,
  output logic                                       full,
  input  wire logic signed [fsdi_pkg::SAMPLE_BITS-1:0] x_real,
  input  wire logic signed [fsdi_pkg::SAMPLE_BITS-1:0] x_imag,
  input  wire logic signed [fsdi_pkg::SAMPLE_BITS-1:0] y_real,
  input  wire logic signed [fsdi_pkg::SAMPLE_BITS-1:0] y_imag,
  input  wire fsdi_pkg::qstat_t                      qstat,
  output logic                                       job_push,
  output fsdi_pkg::job_t                             job,
  output logic [fsdi_pkg::DIV_BITS-1:0]              divisor
);
  import fsdi_pkg::*;

  logic [WIDTH_BITS-1:0] boxcar_width;
  logic [COUNT_BITS-1:0] integration_count;
  logic [WIDTH_BITS-1:0] w_eff;
  logic [COUNT_BITS-1:0] c_eff;
  logic [WIDTH_BITS+COUNT_BITS-1:0] prod;
  logic restart;

  logic [SLOT_BITS-1:0]  slot;
  logic [WIDTH_BITS-1:0] fill;
  logic [WIDTH_BITS-1:0] fill_next;
  logic                  accept;
  logic                  sub_now;
  logic                  primed_now;

  logic signed [2*SAMPLE_BITS:0] px, py, cr, ci;
  det4_t d;
  det4_t mem [MAX_WINDOW];
  det4_t rd;

  logic  a_valid, a_sub, a_primed;
  det4_t a_d;
  logic  b_valid, b_primed;
  logic signed [RUN_BITS-1:0] run_i, run_q, run_u, run_v;
  logic signed [INT_BITS-1:0] int_i, int_q, int_u, int_v;
  logic [COUNT_BITS-1:0] items;
  logic [COUNT_BITS:0]   items_inc;
  logic                  last;
  logic [QCNT_BITS:0]    credit;

  // Effective register values
  always_comb begin
    if (boxcar_width == '0) w_eff = WIDTH_BITS'(1);
    else if (boxcar_width > WIDTH_BITS'(MAX_WINDOW)) w_eff = WIDTH_BITS'(MAX_WINDOW);
    else w_eff = boxcar_width;
    if (integration_count == '0) c_eff = COUNT_BITS'(1);
    else if (integration_count > COUNT_BITS'(COUNT_LIMIT)) c_eff = COUNT_BITS'(COUNT_LIMIT);
    else c_eff = integration_count;
  end

  assign prod    = w_eff * c_eff;
  assign restart = cfg_write &&
                   (cfg_index == REG_BOXCAR_WIDTH || cfg_index == REG_INTEGRATION_COUNT);

  // Configuration registers and registered divisor
  always_ff @(posedge clk) begin
    if (rst) begin
      boxcar_width      <= WIDTH_BITS'(1);
      integration_count <= COUNT_BITS'(1);
    end else if (cfg_write) begin
      if (cfg_index == REG_BOXCAR_WIDTH) boxcar_width <= cfg_data[WIDTH_BITS-1:0];
      else if (cfg_index == REG_INTEGRATION_COUNT) integration_count <= cfg_data;
    end
    divisor <= prod[DIV_BITS-1:0];
  end

  // Reserve queue room for every item in flight
  assign credit = {1'b0, qstat.count} + (QCNT_BITS+1)'(a_valid) + (QCNT_BITS+1)'(b_valid);
  assign full   = (credit >= (QCNT_BITS+1)'(QDEPTH));
  assign accept = push && !full;

  // Detection
  always_comb begin
    px  = x_real * x_real + x_imag * x_imag;
    py  = y_real * y_real + y_imag * y_imag;
    cr  = x_real * y_real + x_imag * y_imag;
    ci  = x_real * y_imag - x_imag * y_real;
    d.i = DET_BITS'(px) + DET_BITS'(py);
    d.q = DET_BITS'(px) - DET_BITS'(py);
    d.u = {cr, 1'b0};
    d.v = {ci, 1'b0};
  end

  assign sub_now    = (fill >= w_eff);
  assign fill_next  = sub_now ? fill : fill + 1'b1;
  assign primed_now = (fill_next >= w_eff);

  // Window memory: old entry read while the new one is written
  always_ff @(posedge clk) begin
    if (accept) begin
      rd        <= mem[slot];
      mem[slot] <= d;
    end
  end

  // Payload of the first and second stages
  always_ff @(posedge clk) begin
    if (accept) begin
      a_d      <= d;
      a_sub    <= sub_now;
      a_primed <= primed_now;
    end
    if (a_valid) b_primed <= a_primed;
  end

  assign items_inc = {1'b0, items} + 1'b1;
  assign last      = (items_inc >= {1'b0, c_eff});
  assign job_push  = b_valid && b_primed && last;
  assign job.i     = int_i + INT_BITS'(run_i);
  assign job.q     = int_q + INT_BITS'(run_q);
  assign job.u     = int_u + INT_BITS'(run_u);
  assign job.v     = int_v + INT_BITS'(run_v);

  // Window control, running sums and integrator
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      slot    <= '0;
      fill    <= '0;
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      run_i   <= '0;
      run_q   <= '0;
      run_u   <= '0;
      run_v   <= '0;
      int_i   <= '0;
      int_q   <= '0;
      int_u   <= '0;
      int_v   <= '0;
      items   <= '0;
    end else begin
      a_valid <= accept;
      b_valid <= a_valid;
      if (accept) begin
        fill <= fill_next;
        slot <= ({1'b0, slot} + 1'b1 == w_eff) ? '0 : slot + 1'b1;
      end
      if (a_valid) begin
        run_i <= run_i + RUN_BITS'(a_d.i) - (a_sub ? RUN_BITS'(rd.i) : '0);
        run_q <= run_q + RUN_BITS'(a_d.q) - (a_sub ? RUN_BITS'(rd.q) : '0);
        run_u <= run_u + RUN_BITS'(a_d.u) - (a_sub ? RUN_BITS'(rd.u) : '0);
        run_v <= run_v + RUN_BITS'(a_d.v) - (a_sub ? RUN_BITS'(rd.v) : '0);
      end
      if (b_valid && b_primed) begin
        if (last) begin
          int_i <= '0;
          int_q <= '0;
          int_u <= '0;
          int_v <= '0;
          items <= '0;
        end else begin
          int_i <= job.i;
          int_q <= job.q;
          int_u <= job.u;
          int_v <= job.v;
          items <= items_inc[COUNT_BITS-1:0];
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/fsdi_back.sv
// Back end: bit-serial division of the four totals and the result register.
`timescale 1ns / 1ps
`default_nettype none
module fsdi_back (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire fsdi_pkg::qstat_t                    qstat,
  input  wire fsdi_pkg::job_t                      job,
  output logic                                     job_pop,
  input  wire logic [fsdi_pkg::DIV_BITS-1:0]       divisor,
  output logic                                     empty,
  input  wire logic                                pop,
  output logic [fsdi_pkg::OUT_IQ_BITS-1:0]         stokes_i,
  output logic signed [fsdi_pkg::OUT_IQ_BITS-1:0]  stokes_q,
  output logic signed [fsdi_pkg::OUT_UV_BITS-1:0]  stokes_u,
  output logic signed [fsdi_pkg::OUT_UV_BITS-1:0]  stokes_v
);
  import fsdi_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]           state;
  logic [STEP_BITS-1:0] step;
  lane_t                lane [4];
  lane_t                lane_next [4];
  logic [3:0]           neg;
  logic [MAG_BITS-1:0]  res [4];
  logic                 out_valid;

  assign job_pop = (state == S_IDLE) && !qstat.empty;
  assign empty   = !out_valid;

  // Division step and sign restore for each lane
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      lane_next[k] = div_step(lane[k], divisor);
      res[k]       = neg[k] ? (~lane[k].num + 1'b1) : lane[k].num;
    end
  end

  // Lane payload and result register
  always_ff @(posedge clk) begin
    if (job_pop) begin
      lane[0] <= '{rem: '0, num: scaled_mag(job.i)};
      lane[1] <= '{rem: '0, num: scaled_mag(job.q)};
      lane[2] <= '{rem: '0, num: scaled_mag(job.u)};
      lane[3] <= '{rem: '0, num: scaled_mag(job.v)};
      neg     <= {job.v[INT_BITS-1], job.u[INT_BITS-1], job.q[INT_BITS-1], job.i[INT_BITS-1]};
    end else if (state == S_DIV) begin
      for (int k = 0; k < 4; k++) lane[k] <= lane_next[k];
    end
    if (state == S_DONE && (!out_valid || pop)) begin
      stokes_i <= res[0][OUT_IQ_BITS-1:0];
      stokes_q <= res[1][OUT_IQ_BITS-1:0];
      stokes_u <= res[2][OUT_UV_BITS-1:0];
      stokes_v <= res[3][OUT_UV_BITS-1:0];
    end
  end

  // Sequencer and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (job_pop) begin
            state <= S_DIV;
            step  <= '0;
          end
        end
        S_DIV: begin
          step <= step + 1'b1;
          if (step == STEP_BITS'(MAG_BITS - 1)) state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || pop) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: design/full_stokes_detector_integrator.sv
// Top level of the full-Stokes detector with boxcar and integrator.
//
// Input channel: one dual-polarization sample (x_real, x_imag, y_real,
// y_imag) is taken when push is high and full is low. Samples are taken one
// per cycle while the job queue has room for the items in flight.
// Result channel: the averaged Stokes I, Q, U, V sit on the result ports
// while empty is low; pop takes them. One result appears for every
// integration_count window totals, after boxcar_width-1 priming samples.
// Path: a sample that closes an integration passes detection and summing,
// the job queue, the one-bit-per-cycle divider and the output register.
// Sustained rate: one sample per cycle while integrations last longer than
// the divider; the shared divider takes no new job until it loads its result.
// A stalled receiver fills the output register and then the four-entry job
// queue, after which full goes high and holds back samples.
// Reset (rst, synchronous) sets boxcar_width and integration_count to 1 and
// empties the window, integrator, queue and output. A write (cfg_write,
// cfg_index, cfg_data) to either register restarts window and integrator.
`timescale 1ns / 1ps
`default_nettype none
module full_stokes_detector_integrator (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_write,
  input  wire logic [fsdi_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  wire logic [fsdi_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  wire logic                                  push,
  output logic                                       full,
  input  wire logic signed [fsdi_pkg::SAMPLE_BITS-1:0] x_real,
  input  wire logic signed [fsdi_pkg::SAMPLE_BITS-1:0] x_imag,
  input  wire logic signed [fsdi_pkg::SAMPLE_BITS-1:0] y_real,
  input  wire logic signed [fsdi_pkg::SAMPLE_BITS-1:0] y_imag,
  output logic                                       empty,
  input  wire logic                                  pop,
  output logic [fsdi_pkg::OUT_IQ_BITS-1:0]           stokes_i,
  output logic signed [fsdi_pkg::OUT_IQ_BITS-1:0]    stokes_q,
  output logic signed [fsdi_pkg::OUT_UV_BITS-1:0]    stokes_u,
  output logic signed [fsdi_pkg::OUT_UV_BITS-1:0]    stokes_v
);
  import fsdi_pkg::*;

  qstat_t              qstat;
  logic                job_push;
  logic                job_pop;
  job_t                job_in;
  job_t                job_out;
  logic [DIV_BITS-1:0] divisor;

  fsdi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .x_real    (x_real),
    .x_imag    (x_imag),
    .y_real    (y_real),
    .y_imag    (y_imag),
    .qstat     (qstat),
    .job_push  (job_push),
    .job       (job_in),
    .divisor   (divisor)
  );

  fsdi_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (job_push),
    .job_in  (job_in),
    .pop     (job_pop),
    .job_out (job_out),
    .stat    (qstat)
  );

  fsdi_back u_back (
    .clk      (clk),
    .rst      (rst),
    .qstat    (qstat),
    .job      (job_out),
    .job_pop  (job_pop),
    .divisor  (divisor),
    .empty    (empty),
    .pop      (pop),
    .stokes_i (stokes_i),
    .stokes_q (stokes_q),
    .stokes_u (stokes_u),
    .stokes_v (stokes_v)
  );

endmodule
`default_nettype wire

FILE: bench/full_stokes_detector_integrator_tb.sv
// Self-checking testbench for the full-Stokes detector with boxcar and integrator.
`timescale 1ns / 1ps
`default_nettype none
module full_stokes_detector_integrator_tb;
  import fsdi_pkg::*;

  // Indexes that name no register
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED_A = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED_B = 2'd3;

  typedef struct {
    logic        [OUT_IQ_BITS-1:0] i;
    logic signed [OUT_IQ_BITS-1:0] q;
    logic signed [OUT_UV_BITS-1:0] u;
    logic signed [OUT_UV_BITS-1:0] v;
  } stokes_t;

  // Scoreboard: Stokes predictor plus queue of expected averages
  class stokes_scoreboard;
    longint  window[4][MAX_WINDOW];
    longint  box_sum[4];
    longint  int_sum[4];
    int      slot;
    int      filled;
    int      summed;
    int      width_reg;
    int      count_reg;
    stokes_t expected_q[$];
    int      errors;
    int      samples;
    int      results;

    function void restart();
      slot = 0;
      filled = 0;
      summed = 0;
      for (int k = 0; k < 4; k++) begin
        box_sum[k] = 0;
        int_sum[k] = 0;
      end
    endfunction

    function void init();
      width_reg = 1;
      count_reg = 1;
      errors = 0;
      samples = 0;
      results = 0;
      restart();
    endfunction

    function void configure(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
      if (idx == REG_BOXCAR_WIDTH) begin
        width_reg = val[WIDTH_BITS-1:0];
        restart();
      end else if (idx == REG_INTEGRATION_COUNT) begin
        count_reg = val;
        restart();
      end
    endfunction

    // Truncating average with fraction bits
    function longint scaled_avg(longint total, longint div);
      longint mag;
      mag = (total < 0) ? -total : total;
      mag = (mag <<< FRACTION_BITS) / div;
      return (total < 0) ? -mag : mag;
    endfunction

    function void note_sample(logic signed [SAMPLE_BITS-1:0] xr, logic signed [SAMPLE_BITS-1:0] xi,
                              logic signed [SAMPLE_BITS-1:0] yr, logic signed [SAMPLE_BITS-1:0] yi);
      longint  px, py, d[4], w, c, a;
      int      s;
      stokes_t r;
      px = longint'(xr) * xr + longint'(xi) * xi;
      py = longint'(yr) * yr + longint'(yi) * yi;
      d[0] = px + py;
      d[1] = px - py;
      d[2] = 2 * (longint'(xr) * yr + longint'(xi) * yi);
      d[3] = 2 * (longint'(xr) * yi - longint'(xi) * yr);
      w = (width_reg == 0) ? 1 : (width_reg > MAX_WINDOW) ? MAX_WINDOW : width_reg;
      c = (count_reg == 0) ? 1 : (count_reg > COUNT_LIMIT) ? COUNT_LIMIT : count_reg;
      s = slot % w;
      samples++;
      if (filled >= w) begin
        for (int k = 0; k < 4; k++) box_sum[k] -= window[k][s];
      end else begin
        filled++;
      end
      for (int k = 0; k < 4; k++) begin
        window[k][s] = d[k];
        box_sum[k] += d[k];
      end
      slot = (s + 1) % w;
      if (filled < w) return;
      for (int k = 0; k < 4; k++) int_sum[k] += box_sum[k];
      summed++;
      if (summed < c) return;
      a = scaled_avg(int_sum[0], w * c); r.i = a[OUT_IQ_BITS-1:0];
      a = scaled_avg(int_sum[1], w * c); r.q = a[OUT_IQ_BITS-1:0];
      a = scaled_avg(int_sum[2], w * c); r.u = a[OUT_UV_BITS-1:0];
      a = scaled_avg(int_sum[3], w * c); r.v = a[OUT_UV_BITS-1:0];
      expected_q.push_back(r);
      for (int k = 0; k < 4; k++) int_sum[k] = 0;
      summed = 0;
    endfunction

    function void check_result(stokes_t act);
      stokes_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result i=%0d q=%0d u=%0d v=%0d",
                 $time, act.i, act.q, act.u, act.v);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      results++;
      if (act.i !== e.i) begin
        $display("%0t: stokes_i expected %0d actual %0d", $time, e.i, act.i); errors++;
      end
      if (act.q !== e.q) begin
        $display("%0t: stokes_q expected %0d actual %0d", $time, e.q, act.q); errors++;
      end
      if (act.u !== e.u) begin
        $display("%0t: stokes_u expected %0d actual %0d", $time, e.u, act.u); errors++;
      end
      if (act.v !== e.v) begin
        $display("%0t: stokes_v expected %0d actual %0d", $time, e.v, act.v); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic push = 1'b0;
  logic full;
  logic signed [SAMPLE_BITS-1:0] x_real = '0, x_imag = '0, y_real = '0, y_imag = '0;
  logic empty;
  logic pop = 1'b0;
  logic [OUT_IQ_BITS-1:0] stokes_i;
  logic signed [OUT_IQ_BITS-1:0] stokes_q;
  logic signed [OUT_UV_BITS-1:0] stokes_u, stokes_v;

  stokes_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;

  full_stokes_detector_integrator u_dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .full(full), .x_real(x_real), .x_imag(x_imag), .y_real(y_real),
    .y_imag(y_imag), .empty(empty), .pop(pop), .stokes_i(stokes_i), .stokes_q(stokes_q),
    .stokes_u(stokes_u), .stokes_v(stokes_v)
  );

  always #5 clk = ~clk;

  initial begin
    #20ms;
    $display("full_stokes_detector_integrator regression: fail");
    $finish;
  end

  // Receiver: check each popped transaction, then pick next pop
  always @(posedge clk) begin
    stokes_t act;
    if (!rst && pop && !empty) begin
      act.i = stokes_i; act.q = stokes_q; act.u = stokes_u; act.v = stokes_v;
      sb.check_result(act);
    end
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one sample; returns at the edge where it is taken
  task automatic send_sample(logic [SAMPLE_BITS-1:0] xr, logic [SAMPLE_BITS-1:0] xi,
                             logic [SAMPLE_BITS-1:0] yr, logic [SAMPLE_BITS-1:0] yi);
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    push <= 1'b1;
    x_real <= xr; x_imag <= xi; y_real <= yr; y_imag <= yi;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_sample(xr, xi, yr, yi);
  endtask

  task automatic send_random(int n);
    logic [SAMPLE_BITS-1:0] f[4];
    for (int j = 0; j < n; j++) begin
      for (int k = 0; k < 4; k++) begin
        case ($urandom_range(9))
          0: f[k] = 8'h80;
          1: f[k] = 8'h7f;
          default: f[k] = SAMPLE_BITS'($urandom);
        endcase
      end
      send_sample(f[0], f[1], f[2], f[3]);
    end
  endtask

  // Drain, let in-flight work settle, then write one register
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    push <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg_write <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    sb.configure(idx, val);
    cfg_write <= 1'b0;
  endtask

  initial begin
    int widths[8]  = '{64, 1, 0, 127, 5, 3, 17, 2};
    int counts[8]  = '{1, 1, 3, 2, 7, 0, 4, 1};
    sb.init();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes at reset settings, then zero and unused register writes
    for (int m = 0; m < 16; m++)
      send_sample(m[0] ? 8'h7f : 8'h80, m[1] ? 8'h7f : 8'h80,
                  m[2] ? 8'h7f : 8'h80, m[3] ? 8'h7f : 8'h80);
    send_sample(8'h00, 8'h00, 8'h00, 8'h00);
    send_sample(8'hff, 8'h01, 8'h01, 8'hff);
    write_reg(REG_BOXCAR_WIDTH, 17'd0);
    send_random(2);
    write_reg(REG_INTEGRATION_COUNT, 17'd0);
    send_random(2);
    write_reg(REG_UNUSED_A, 17'd5);
    send_random(1);
    write_reg(REG_UNUSED_B, 17'd9);
    send_random(1);

    // Random phases under three idling schemes
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 37 : (mode == 1) ? 87 : 0;
      recv_idle_pct = (mode == 0) ? 87 : (mode == 1) ? 37 : 0;
      for (int p = 0; p < 8; p++) begin
        write_reg(REG_BOXCAR_WIDTH, CFG_DATA_BITS'(widths[(p + mode) % 8]));
        write_reg(REG_INTEGRATION_COUNT, CFG_DATA_BITS'(counts[(p + 3 * mode) % 8]));
        send_random(55);
      end
    end

    // Long receiver stall with one result per sample so the input backs up
    write_reg(REG_BOXCAR_WIDTH, 17'd1);
    write_reg(REG_INTEGRATION_COUNT, 17'd1);
    @(posedge clk);
    hold_cycles <= 1500;
    send_random(30);

    // Counts at and above the limit: no result within a short run
    write_reg(REG_INTEGRATION_COUNT, 17'h1ffff);
    send_random(20);
    write_reg(REG_INTEGRATION_COUNT, 17'h10000);
    send_random(20);

    push <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Covered %0d samples and %0d checked results over widths 0..127,",
             sb.samples, sb.results);
    $display("counts 0..131071, ignored indexes, three idling schemes and a long stall.");
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("full_stokes_detector_integrator regression: pass");
    else
      $display("full_stokes_detector_integrator regression: fail");
    $finish;
  end
endmodule
`default_nettype wire
